>>> rtl/core/pilp_pkg.sv
// Shared types, character codes and decode helpers for the literal parser.
package pilp_pkg;

   // Parse phase; the unused code is handled as start of string.
   typedef enum logic [2:0] {
      PH_START      = 3'd0,
      PH_ZERO       = 3'd1,
      PH_DEC_LEAD   = 3'd2,
      PH_DEC_DIGITS = 3'd3,
      PH_HEX        = 3'd4,
      PH_BIN        = 3'd5,
      PH_OCT        = 3'd6
   } phase_type;

   // Control state carried between characters.
   typedef struct packed {
      phase_type phase;
      logic      negative;
      logic      invalid_seen;
      logic      stopped;
   } ctl_type;

   localparam ctl_type CTL_CLEAR = '{phase: PH_START, negative: 1'b0,
                                     invalid_seen: 1'b0, stopped: 1'b0};

   localparam int unsigned OUT_WIDTH = 32;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_TWO   = 8'd50;
   localparam logic [7:0] CH_EIGHT = 8'd56;
   localparam logic [7:0] CH_NINE  = 8'd57;
   localparam logic [7:0] CH_UP_A  = 8'd65;
   localparam logic [7:0] CH_UP_F  = 8'd70;
   localparam logic [7:0] CH_LO_A  = 8'd97;
   localparam logic [7:0] CH_LO_F  = 8'd102;
   localparam logic [7:0] CH_UP_B  = 8'd66;
   localparam logic [7:0] CH_LO_B  = 8'd98;
   localparam logic [7:0] CH_UP_X  = 8'd88;
   localparam logic [7:0] CH_LO_X  = 8'd120;
   localparam logic [7:0] UP_HEX_BIAS = 8'd55;
   localparam logic [7:0] LO_HEX_BIAS = 8'd87;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // {valid, nibble}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] d;
      d = 8'd0;
      if (is_dec(c)) begin
         d = c - CH_ZERO;
         return {1'b1, d[3:0]};
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         d = c - UP_HEX_BIAS;
         return {1'b1, d[3:0]};
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         d = c - LO_HEX_BIAS;
         return {1'b1, d[3:0]};
      end
      return 5'd0;
   endfunction

endpackage

>>> rtl/core/pilp_step.sv
// Per-character next-state and final-value logic for the literal parser.
module pilp_step
   import pilp_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic [7:0]             ch,
   input  ctl_type                ctl,
   input  logic [VALUE_WIDTH-1:0] acc,
   output ctl_type                ctl_nxt,
   output logic [VALUE_WIDTH-1:0] acc_nxt,
   output logic [VALUE_WIDTH-1:0] final_val
);

   logic [4:0]             hex_d;
   logic [7:0]             dig;
   logic [VALUE_WIDTH-1:0] dig_ext;
   logic [VALUE_WIDTH-1:0] acc_dec;
   logic [VALUE_WIDTH-1:0] acc_hex;
   logic [VALUE_WIDTH-1:0] acc_bin;
   logic [VALUE_WIDTH-1:0] acc_oct;
   logic                   is_oct;
   logic                   is_bin;

   assign hex_d   = hex_decode(ch);
   assign dig     = ch - CH_ZERO;
   assign dig_ext = {{(VALUE_WIDTH-4){1'b0}}, dig[3:0]};
   assign is_oct  = (ch > 8'd47) && (ch < CH_EIGHT);
   assign is_bin  = (ch > 8'd47) && (ch < CH_TWO);
   // acc * 10 as two shifts and an add
   assign acc_dec = (acc << 3) + (acc << 1) + dig_ext;
   assign acc_hex = (acc << 4) + {{(VALUE_WIDTH-4){1'b0}}, hex_d[3:0]};
   assign acc_bin = (acc << 1) + dig_ext;
   assign acc_oct = (acc << 3) + dig_ext;

   always_comb begin
      ctl_nxt = ctl;
      acc_nxt = acc;
      if (ch == CH_NUL) begin
         ctl_nxt = CTL_CLEAR;
         acc_nxt = '0;
      end else begin
         unique case (ctl.phase)
            PH_ZERO: begin
               if (ch == CH_LO_X || ch == CH_UP_X) begin
                  ctl_nxt.phase = PH_HEX;
               end else if (ch == CH_LO_B || ch == CH_UP_B) begin
                  ctl_nxt.phase = PH_BIN;
               end else begin
                  ctl_nxt.phase = PH_OCT;
                  if (ctl.invalid_seen) begin
                  end else if (is_oct) begin
                     acc_nxt = acc_oct;
                  end else begin
                     ctl_nxt.invalid_seen = 1'b1;
                  end
               end
            end
            PH_DEC_LEAD, PH_DEC_DIGITS: begin
               if (ctl.stopped) begin
               end else if (is_dec(ch)) begin
                  acc_nxt       = acc_dec;
                  ctl_nxt.phase = PH_DEC_DIGITS;
               end else if (ctl.phase == PH_DEC_LEAD && is_space(ch)) begin
               end else if (ctl.phase == PH_DEC_LEAD &&
                            (ch == CH_PLUS || ch == CH_MINUS)) begin
                  ctl_nxt.negative = (ch == CH_MINUS);
                  ctl_nxt.phase    = PH_DEC_DIGITS;
               end else begin
                  ctl_nxt.stopped = 1'b1;
               end
            end
            PH_HEX: begin
               if (!ctl.stopped) begin
                  if (hex_d[4]) begin
                     acc_nxt = acc_hex;
                  end else begin
                     acc_nxt         = '0;
                     ctl_nxt.stopped = 1'b1;
                  end
               end
            end
            PH_BIN: begin
               if (ctl.invalid_seen) begin
               end else if (is_bin) begin
                  acc_nxt = acc_bin;
               end else begin
                  ctl_nxt.invalid_seen = 1'b1;
               end
            end
            PH_OCT: begin
               if (ctl.invalid_seen) begin
               end else if (is_oct) begin
                  acc_nxt = acc_oct;
               end else begin
                  ctl_nxt.invalid_seen = 1'b1;
               end
            end
            default: begin
               // start of string (and the unused code)
               if (ch == CH_ZERO) begin
                  ctl_nxt       = CTL_CLEAR;
                  ctl_nxt.phase = PH_ZERO;
               end else begin
                  ctl_nxt       = CTL_CLEAR;
                  acc_nxt       = '0;
                  ctl_nxt.phase = PH_DEC_LEAD;
                  if (is_dec(ch)) begin
                     acc_nxt       = dig_ext;
                     ctl_nxt.phase = PH_DEC_DIGITS;
                  end else if (is_space(ch)) begin
                  end else if (ch == CH_PLUS || ch == CH_MINUS) begin
                     ctl_nxt.negative = (ch == CH_MINUS);
                     ctl_nxt.phase    = PH_DEC_DIGITS;
                  end else begin
                     ctl_nxt.stopped = 1'b1;
                  end
               end
            end
         endcase
      end
   end

   always_comb begin
      unique case (ctl.phase)
         PH_DEC_LEAD, PH_DEC_DIGITS: final_val = ctl.negative ? (-acc) : acc;
         PH_HEX:                     final_val = acc;
         PH_BIN, PH_OCT:             final_val = ctl.invalid_seen ? '0 : acc;
         default:                    final_val = '0;
      endcase
   end

endmodule

>>> rtl/core/prefixed_integer_literal_parser.sv
// A terminating zero character gives its value on rsp_value in the cycle after acceptance.
// Throughput: one character per cycle while req_ready is high; the parse state updates in a single pass per character.
// Only a held result that the sink does not take stalls the input (req_ready is low then).
// Reset (synchronous, active high) clears phase, flags, accumulator and the result valid.
// Top level: character parser state plus a one-entry result register.
module prefixed_integer_literal_parser
   import pilp_pkg::*;
#(
   parameter int unsigned VALUE_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value
);

   // parse state, updated once per accepted character
   ctl_type                ctl_ff, ctl_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [VALUE_WIDTH-1:0] final_val;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic [OUT_WIDTH-1:0]   final_ext;

   logic                   req_take;
   logic                   end_of_str;

   // Output register is free when empty or draining this cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_take   = req_valid && req_ready;
   assign end_of_str = (req_ch == CH_NUL);

   pilp_step #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) u_step (
      .ch        (req_ch),
      .ctl       (ctl_ff),
      .acc       (acc_ff),
      .ctl_nxt   (ctl_in),
      .acc_nxt   (acc_in),
      .final_val (final_val)
   );

   // Sign-extend or truncate the accumulator width to the 32-bit result.
   if (VALUE_WIDTH >= OUT_WIDTH) begin : g_trunc
      assign final_ext = final_val[OUT_WIDTH-1:0];
   end else begin : g_sext
      assign final_ext = {{(OUT_WIDTH-VALUE_WIDTH){final_val[VALUE_WIDTH-1]}}, final_val};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      if (req_take && end_of_str) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = final_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff       <= CTL_CLEAR;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            ctl_ff <= ctl_in;
            acc_ff <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

>>> rtl/core/pilp_checker.sv
// Port-level checker for the literal parser, bound to the top level.
module pilp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [7:0]         req_ch,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value
);

   // held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // a fresh result needs an accepted terminator
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ($past(!rsp_valid) || $past(rsp_ready)) |->
         $past(req_valid && req_ready && req_ch == 8'd0))
      else $error("result without terminator");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_ch != 8'd0 && (!rsp_valid || rsp_ready) |=> !rsp_valid)
      else $error("result from non-terminating item");

endmodule

bind prefixed_integer_literal_parser pilp_checker u_pilp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_ch    (req_ch),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_value (rsp_value)
);
